>>> hw/rtl/tci_pkg.sv
// Shared widths, constants and beat types of the threshold crossing interpolator.
package tci_pkg;

  localparam int XW   = 16;           // point_x
  localparam int YW   = 24;           // point_y and threshold
  localparam int ErrW = 23;           // point_y_err
  localparam int AW   = YW + 2;       // shifted numerator and denominator terms
  localparam int MW   = AW - 1;       // magnitudes of those terms
  localparam int DxW  = XW;           // magnitude of the x difference
  localparam int PW   = MW + DxW;     // product
  localparam int NW   = PW + 1;       // rounded dividend and quotient
  localparam int RW   = NW + 2;       // interpolated x before saturation
  localparam int AccW = RW + 2;       // sum of the two deviations
  localparam int CntW = $clog2(NW);

  localparam int CxW  = 32;
  localparam int CeW  = 31;

  localparam logic [CxW-1:0] NoCrossX = CxW'(9999);
  localparam logic [CeW-1:0] ErrMax   = {CeW{1'b1}};

  typedef struct packed {
    logic signed [XW-1:0]   point_x;
    logic signed [YW-1:0]   point_y;
    logic        [ErrW-1:0] point_y_err;
    logic                   last_point;
  } in_beat_t;

  typedef struct packed {
    logic                  crossing_found;
    logic signed [CxW-1:0] crossing_x;
    logic        [CeW-1:0] crossing_err;
    logic                  divide_fault;
  } out_beat_t;

endpackage

>>> hw/rtl/threshold_crossing_interpolator_unit.sv
// Threshold crossing interpolator: serial multiply and divide per shifted interpolation.
// A point that does not start a crossing is taken while idle; a last point then passes
// through the emit state, which loads its result beat into the output register once free.
// The crossing point runs up to three interpolations on one shift-add multiplier
// and one restoring divider (one quotient bit a cycle).
// Reset (rst_ni low, asynchronous) clears scan state, the threshold and the output valid.
module threshold_crossing_interpolator_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  tci_pkg::in_beat_t        in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output tci_pkg::out_beat_t       out_data_o,
  input  logic                     cfg_we_i,
  input  logic [tci_pkg::YW-1:0]   cfg_wdata_i
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SETUP = 4'd1;
  localparam logic [3:0] S_ABS   = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_PREP  = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_RES   = 4'd6;
  localparam logic [3:0] S_DEV   = 4'd7;
  localparam logic [3:0] S_ACC   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;

  localparam logic [1:0] VarNom = 2'd0;
  localparam logic [1:0] VarUp  = 2'd1;
  localparam logic [1:0] VarDn  = 2'd2;

  logic [3:0] state_q, state_d;
  logic [1:0] var_q, var_d;
  logic [tci_pkg::CntW-1:0] cnt_q, cnt_d;

  logic [tci_pkg::YW-1:0] thr_q;

  logic [tci_pkg::XW-1:0]   prev_x_q, prev_x_d;
  logic [tci_pkg::YW-1:0]   prev_y_q, prev_y_d;
  logic [tci_pkg::ErrW-1:0] prev_err_q, prev_err_d;
  logic have_prev_q, have_prev_d;
  logic found_q, found_d;
  logic [tci_pkg::CxW-1:0] held_x_q, held_x_d;
  logic [tci_pkg::CeW-1:0] held_err_q, held_err_d;
  logic held_fault_q, held_fault_d;

  logic [tci_pkg::XW-1:0]   cur_x_q, cur_x_d;
  logic [tci_pkg::YW-1:0]   cur_y_q, cur_y_d;
  logic [tci_pkg::ErrW-1:0] cur_err_q, cur_err_d;
  logic last_q, last_d;

  logic [tci_pkg::AW-1:0]   a_q, a_d;
  logic [tci_pkg::AW-1:0]   dy_q, dy_d;
  logic [tci_pkg::DxW:0]    dx_q, dx_d;
  logic [tci_pkg::MW-1:0]   mcand_q, mcand_d;
  logic [tci_pkg::MW-1:0]   dv_q, dv_d;
  logic sign_q, sign_d;
  logic [tci_pkg::PW-1:0]   p_q, p_d;
  logic [tci_pkg::NW-1:0]   num_q, num_d;
  logic [tci_pkg::MW-1:0]   rem_q, rem_d;
  logic [tci_pkg::RW-1:0]   r_q, r_d;
  logic [tci_pkg::RW-1:0]   nom_q, nom_d;
  logic [tci_pkg::RW:0]     diff_q, diff_d;
  logic [tci_pkg::AccW-1:0] acc_q, acc_d;
  logic fault_q, fault_d;

  logic out_valid_q, out_valid_d;
  tci_pkg::out_beat_t out_q, out_d;

  logic                     in_acc;
  logic                     straddle;
  logic [tci_pkg::YW:0]     y0k, y1k;
  logic [tci_pkg::MW:0]     mul_sum;
  logic [tci_pkg::MW:0]     trial;
  logic [tci_pkg::MW+1:0]   trial_sub;
  logic [tci_pkg::RW-1:0]   q_ext;
  logic [tci_pkg::AccW-1:0] h_sum;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign straddle = have_prev_q && !found_q &&
      (($signed(prev_y_q) > $signed(thr_q) && $signed(in_data_i.point_y) < $signed(thr_q)) ||
       ($signed(prev_y_q) < $signed(thr_q) && $signed(in_data_i.point_y) > $signed(thr_q)));

  always_comb begin
    y0k = {prev_y_q[tci_pkg::YW-1], prev_y_q};
    y1k = {cur_y_q[tci_pkg::YW-1], cur_y_q};
    case (var_q)
      VarUp: begin
        y0k = y0k + {2'b00, prev_err_q};
        y1k = y1k + {2'b00, cur_err_q};
      end
      VarDn: begin
        y0k = y0k - {2'b00, prev_err_q};
        y1k = y1k - {2'b00, cur_err_q};
      end
      default: ;
    endcase
  end

  assign mul_sum   = {1'b0, p_q[tci_pkg::PW-1:tci_pkg::DxW]} +
                     (p_q[0] ? {1'b0, mcand_q} : '0);
  assign trial     = {rem_q, num_q[tci_pkg::NW-1]};
  assign trial_sub = {1'b0, trial} - {2'b00, dv_q};
  assign q_ext     = {2'b00, num_q};
  assign h_sum     = acc_q + tci_pkg::AccW'(1);

  always_comb begin
    state_d      = state_q;
    var_d        = var_q;
    cnt_d        = cnt_q;
    prev_x_d     = prev_x_q;
    prev_y_d     = prev_y_q;
    prev_err_d   = prev_err_q;
    have_prev_d  = have_prev_q;
    found_d      = found_q;
    held_x_d     = held_x_q;
    held_err_d   = held_err_q;
    held_fault_d = held_fault_q;
    cur_x_d      = cur_x_q;
    cur_y_d      = cur_y_q;
    cur_err_d    = cur_err_q;
    last_d       = last_q;
    a_d          = a_q;
    dy_d         = dy_q;
    dx_d         = dx_q;
    mcand_d      = mcand_q;
    dv_d         = dv_q;
    sign_d       = sign_q;
    p_d          = p_q;
    num_d        = num_q;
    rem_d        = rem_q;
    r_d          = r_q;
    nom_d        = nom_q;
    diff_d       = diff_q;
    acc_d        = acc_q;
    fault_d      = fault_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (straddle) begin
            cur_x_d   = in_data_i.point_x;
            cur_y_d   = in_data_i.point_y;
            cur_err_d = in_data_i.point_y_err;
            last_d    = in_data_i.last_point;
            var_d     = VarNom;
            fault_d   = 1'b0;
            acc_d     = '0;
            state_d   = S_SETUP;
          end else begin
            prev_x_d    = in_data_i.point_x;
            prev_y_d    = in_data_i.point_y;
            prev_err_d  = in_data_i.point_y_err;
            have_prev_d = 1'b1;
            if (in_data_i.last_point) begin
              state_d = S_EMIT;
            end
          end
        end
      end
      S_SETUP: begin
        a_d     = {thr_q[tci_pkg::YW-1], thr_q[tci_pkg::YW-1], thr_q} -
                  {y0k[tci_pkg::YW], y0k};
        dy_d    = {y1k[tci_pkg::YW], y1k} - {y0k[tci_pkg::YW], y0k};
        dx_d    = {cur_x_q[tci_pkg::XW-1], cur_x_q} - {prev_x_q[tci_pkg::XW-1], prev_x_q};
        state_d = S_ABS;
      end
      S_ABS: begin
        mcand_d = a_q[tci_pkg::AW-1] ? tci_pkg::MW'(~a_q + 1'b1) : a_q[tci_pkg::MW-1:0];
        dv_d    = dy_q[tci_pkg::AW-1] ? tci_pkg::MW'(~dy_q + 1'b1) : dy_q[tci_pkg::MW-1:0];
        p_d     = {{tci_pkg::MW{1'b0}},
                   (dx_q[tci_pkg::DxW] ? tci_pkg::DxW'(~dx_q + 1'b1)
                                       : dx_q[tci_pkg::DxW-1:0])};
        sign_d  = a_q[tci_pkg::AW-1] ^ dy_q[tci_pkg::AW-1] ^ dx_q[tci_pkg::DxW];
        cnt_d   = tci_pkg::CntW'(tci_pkg::DxW - 1);
        if (dy_q == '0) begin
          fault_d = 1'b1;
          if (var_q == VarDn) begin
            state_d = S_DONE;
          end else begin
            var_d   = VarDn;
            state_d = S_SETUP;
          end
        end else begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        p_d   = {mul_sum, p_q[tci_pkg::DxW-1:1]};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        num_d   = {1'b0, p_q} +
                  {{(tci_pkg::NW - tci_pkg::MW + 1){1'b0}}, dv_q[tci_pkg::MW-1:1]};
        rem_d   = '0;
        cnt_d   = tci_pkg::CntW'(tci_pkg::NW - 1);
        state_d = S_DIV;
      end
      S_DIV: begin
        if (!trial_sub[tci_pkg::MW+1]) begin
          rem_d = trial_sub[tci_pkg::MW-1:0];
          num_d = {num_q[tci_pkg::NW-2:0], 1'b1};
        end else begin
          rem_d = trial[tci_pkg::MW-1:0];
          num_d = {num_q[tci_pkg::NW-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_RES;
        end
      end
      S_RES: begin
        r_d = {{(tci_pkg::RW - tci_pkg::XW){prev_x_q[tci_pkg::XW-1]}}, prev_x_q} +
              (q_ext ^ {tci_pkg::RW{sign_q}}) + tci_pkg::RW'(sign_q);
        if (var_q == VarNom) begin
          nom_d   = r_d;
          var_d   = VarUp;
          state_d = S_SETUP;
        end else begin
          state_d = S_DEV;
        end
      end
      S_DEV: begin
        diff_d  = {r_q[tci_pkg::RW-1], r_q} - {nom_q[tci_pkg::RW-1], nom_q};
        state_d = S_ACC;
      end
      S_ACC: begin
        acc_d = acc_q + tci_pkg::AccW'(diff_q ^ {(tci_pkg::RW+1){diff_q[tci_pkg::RW]}}) +
                tci_pkg::AccW'(diff_q[tci_pkg::RW]);
        if (var_q == VarDn) begin
          state_d = S_DONE;
        end else begin
          var_d   = VarDn;
          state_d = S_SETUP;
        end
      end
      S_DONE: begin
        if ((nom_q[tci_pkg::RW-1:tci_pkg::CxW-1] == '0) ||
            (nom_q[tci_pkg::RW-1:tci_pkg::CxW-1] == '1)) begin
          held_x_d = nom_q[tci_pkg::CxW-1:0];
        end else begin
          held_x_d = {nom_q[tci_pkg::RW-1], {(tci_pkg::CxW-1){~nom_q[tci_pkg::RW-1]}}};
        end
        if (fault_q || (h_sum[tci_pkg::AccW-1:tci_pkg::CeW+1] != '0)) begin
          held_err_d = tci_pkg::ErrMax;
        end else begin
          held_err_d = h_sum[tci_pkg::CeW:1];
        end
        held_fault_d = fault_q;
        found_d      = 1'b1;
        prev_x_d     = cur_x_q;
        prev_y_d     = cur_y_q;
        prev_err_d   = cur_err_q;
        have_prev_d  = 1'b1;
        state_d      = last_q ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          if (found_q) begin
            out_d.crossing_found = 1'b1;
            out_d.crossing_x     = held_x_q;
            out_d.crossing_err   = held_err_q;
            out_d.divide_fault   = held_fault_q;
          end else begin
            out_d.crossing_found = 1'b0;
            out_d.crossing_x     = tci_pkg::NoCrossX;
            out_d.crossing_err   = '0;
            out_d.divide_fault   = 1'b0;
          end
          prev_x_d     = '0;
          prev_y_d     = '0;
          prev_err_d   = '0;
          have_prev_d  = 1'b0;
          found_d      = 1'b0;
          held_x_d     = '0;
          held_err_d   = '0;
          held_fault_d = 1'b0;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      var_q        <= VarNom;
      cnt_q        <= '0;
      thr_q        <= '0;
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      prev_err_q   <= '0;
      have_prev_q  <= 1'b0;
      found_q      <= 1'b0;
      held_x_q     <= '0;
      held_err_q   <= '0;
      held_fault_q <= 1'b0;
      fault_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      var_q        <= var_d;
      cnt_q        <= cnt_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      prev_x_q     <= prev_x_d;
      prev_y_q     <= prev_y_d;
      prev_err_q   <= prev_err_d;
      have_prev_q  <= have_prev_d;
      found_q      <= found_d;
      held_x_q     <= held_x_d;
      held_err_q   <= held_err_d;
      held_fault_q <= held_fault_d;
      fault_q      <= fault_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_x_q   <= cur_x_d;
    cur_y_q   <= cur_y_d;
    cur_err_q <= cur_err_d;
    last_q    <= last_d;
    a_q       <= a_d;
    dy_q      <= dy_d;
    dx_q      <= dx_d;
    mcand_q   <= mcand_d;
    dv_q      <= dv_d;
    sign_q    <= sign_d;
    p_q       <= p_d;
    num_q     <= num_d;
    rem_q     <= rem_d;
    r_q       <= r_d;
    nom_q     <= nom_d;
    diff_q    <= diff_d;
    acc_q     <= acc_d;
    out_q     <= out_d;
  end

  a_new_beat_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_EMIT)
    else $error("result beat not loaded from emit state");

  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (dv_q != '0))
    else $error("divide with zero divisor");

  a_no_cross_sentinel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.crossing_found) |->
      (out_q.crossing_x == tci_pkg::NoCrossX && out_q.crossing_err == '0 &&
       !out_q.divide_fault))
    else $error("bad no-crossing beat");

  a_fault_err_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.divide_fault) |->
      (out_q.crossing_found && out_q.crossing_err == tci_pkg::ErrMax))
    else $error("fault beat without saturated error");

endmodule

>>> bench/tci_crossing_check.sv
// Checker for the threshold crossing interpolator: predicts crossing results and compares beats.
`timescale 1ns / 1ps
module tci_crossing_check (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  tci_pkg::in_beat_t      in_data_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  tci_pkg::out_beat_t     out_data_i,
  input  logic                   cfg_we_i,
  input  logic [tci_pkg::YW-1:0] cfg_wdata_i,
  output int                     error_count_o,
  output int                     pending_o
);

  localparam longint XHigh  = 64'sd2147483647;
  localparam longint XLow   = -64'sd2147483648;
  localparam longint ErrTop = 64'sd2147483647;

  longint             threshold;
  longint             prev_x, prev_y, prev_err;
  bit                 have_prev, found;
  longint             held_x, held_err;
  bit                 held_fault;
  int                 errors;
  tci_pkg::out_beat_t results_due[$];

  function automatic longint round_div(input longint num, input longint den);
    longint mag_n, mag_d, q;
    mag_n = (num < 0) ? -num : num;
    mag_d = (den < 0) ? -den : den;
    q = (mag_n + mag_d / 2) / mag_d;
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  function automatic bit interpolate(input longint x0, input longint y0, input longint x1,
                                     input longint y1, input longint thr, output longint xc);
    longint dy;
    dy = y1 - y0;
    xc = 0;
    if (dy == 0) return 1'b0;
    xc = round_div((thr - y0) * (x1 - x0), dy) + x0;
    return 1'b1;
  endfunction

  function automatic longint distance(input longint a, input longint b);
    return (a >= b) ? a - b : b - a;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    longint             px, py, pe, nom, up, dn, half;
    bit                 ok_up, ok_dn;
    tci_pkg::out_beat_t want;
    if (!rst_ni) begin
      threshold  = 0;
      prev_x     = 0;
      prev_y     = 0;
      prev_err   = 0;
      have_prev  = 1'b0;
      found      = 1'b0;
      held_x     = 0;
      held_err   = 0;
      held_fault = 1'b0;
      errors     = 0;
      results_due.delete();
      error_count_o <= 0;
      pending_o     <= 0;
    end else begin
      if (cfg_we_i) threshold = longint'($signed(cfg_wdata_i));

      if (in_valid_i && !in_stall_i) begin
        px = longint'($signed(in_data_i.point_x));
        py = longint'($signed(in_data_i.point_y));
        pe = longint'(in_data_i.point_y_err);
        if (have_prev && !found &&
            ((prev_y > threshold && py < threshold) ||
             (prev_y < threshold && py > threshold))) begin
          void'(interpolate(prev_x, prev_y, px, py, threshold, nom));
          ok_up = interpolate(prev_x, prev_y + prev_err, px, py + pe, threshold, up);
          ok_dn = interpolate(prev_x, prev_y - prev_err, px, py - pe, threshold, dn);
          held_x = (nom > XHigh) ? XHigh : ((nom < XLow) ? XLow : nom);
          if (ok_up && ok_dn) begin
            half = (distance(up, nom) + distance(dn, nom) + 1) >>> 1;
            held_err   = (half > ErrTop) ? ErrTop : half;
            held_fault = 1'b0;
          end else begin
            held_err   = ErrTop;
            held_fault = 1'b1;
          end
          found = 1'b1;
        end
        prev_x    = px;
        prev_y    = py;
        prev_err  = pe;
        have_prev = 1'b1;

        if (in_data_i.last_point) begin
          if (found) begin
            want.crossing_found = 1'b1;
            want.crossing_x     = tci_pkg::CxW'(held_x);
            want.crossing_err   = tci_pkg::CeW'(held_err);
            want.divide_fault   = held_fault;
          end else begin
            want.crossing_found = 1'b0;
            want.crossing_x     = tci_pkg::NoCrossX;
            want.crossing_err   = '0;
            want.divide_fault   = 1'b0;
          end
          results_due.insert(results_due.size(), want);
          prev_x     = 0;
          prev_y     = 0;
          prev_err   = 0;
          have_prev  = 1'b0;
          found      = 1'b0;
          held_x     = 0;
          held_err   = 0;
          held_fault = 1'b0;
        end
      end

      if (out_valid_i && !out_stall_i) begin
        if (results_due.size() == 0) begin
          if (errors < 10)
            $display("%0t: unexpected beat found=%0d x=%0d err=%0d fault=%0d", $realtime,
                     out_data_i.crossing_found, out_data_i.crossing_x,
                     out_data_i.crossing_err, out_data_i.divide_fault);
          errors++;
        end else begin
          want = results_due.pop_front();
          if (out_data_i.crossing_found !== want.crossing_found ||
              out_data_i.crossing_x !== want.crossing_x ||
              out_data_i.crossing_err !== want.crossing_err ||
              out_data_i.divide_fault !== want.divide_fault) begin
            if (errors < 10)
              $display("%0t: exp f=%0d x=%0d e=%0d d=%0d, got f=%0d x=%0d e=%0d d=%0d",
                       $realtime, want.crossing_found, want.crossing_x, want.crossing_err,
                       want.divide_fault, out_data_i.crossing_found, out_data_i.crossing_x,
                       out_data_i.crossing_err, out_data_i.divide_fault);
            errors++;
          end
        end
      end

      error_count_o <= errors;
      pending_o     <= results_due.size();
    end
  end

endmodule

>>> bench/threshold_crossing_interpolator_unit_tb.sv
// Testbench top for the threshold crossing interpolator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module threshold_crossing_interpolator_unit_tb;

  localparam int SettleCycles = 300;
  localparam int YHigh        = 8388607;
  localparam int YLow         = -8388608;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  tci_pkg::in_beat_t      in_data   = '0;
  logic                   out_stall = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [tci_pkg::YW-1:0] cfg_wdata = '0;
  logic                   steady    = 1'b0;
  logic                   in_stall, out_valid;
  tci_pkg::out_beat_t     out_data;
  int                     error_count, results_pending;
  int                     thr_now = 0;
  int                     points_sent = 0;

  always #5 clk = ~clk;

  threshold_crossing_interpolator_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  tci_crossing_check crossing_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_data_i    (out_data),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .error_count_o (error_count),
    .pending_o     (results_pending)
  );

  always @(posedge clk) begin
    out_stall <= steady ? 1'b0 : ($urandom_range(99) < 37);
  end

  task automatic send_point(input int x, input int y, input int e, input bit last);
    tci_pkg::in_beat_t b;
    b.point_x     = tci_pkg::XW'(x);
    b.point_y     = tci_pkg::YW'(y);
    b.point_y_err = tci_pkg::ErrW'(e);
    b.last_point  = last;
    while (!steady && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do begin
      @(posedge clk);
    end while (in_stall);
    points_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (results_pending != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_threshold(input int value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= tci_pkg::YW'(value);
    @(posedge clk);
    cfg_we  <= 1'b0;
    thr_now  = value;
  endtask

  function automatic int pick_current(input int thr, input bit noise);
    int mode, v;
    mode = $urandom_range(9);
    if (noise || mode < 2) return int'($signed(tci_pkg::YW'($urandom)));
    if (mode == 2) return thr;
    if (mode < 5) v = thr + int'($urandom_range(200000)) - 100000;
    else v = thr + int'($urandom_range(2000)) - 1000;
    if (v > YHigh) v = YHigh;
    if (v < YLow) v = YLow;
    return v;
  endfunction

  function automatic int pick_error(input bit noise);
    int mode;
    mode = $urandom_range(9);
    if (noise || mode < 3) return int'($urandom_range(8388607));
    if (mode < 5) return 0;
    return int'($urandom_range(300));
  endfunction

  task automatic random_scan();
    int len, x;
    bit noise;
    noise = ($urandom_range(9) == 0);
    len   = ($urandom_range(9) == 0) ? int'($urandom_range(20, 9)) : int'($urandom_range(6, 1));
    x     = int'($urandom_range(65535)) - 32768;
    for (int k = 0; k < len; k++) begin
      if (noise || $urandom_range(3) == 0) x = int'($urandom_range(65535)) - 32768;
      else x = x + int'($urandom_range(60));
      send_point(x, pick_current(thr_now, noise), pick_error(noise),
                 noise ? bit'($urandom_range(1)) && k == len - 1 || k == len - 1 : k == len - 1);
    end
  endtask

  initial begin
    int goal, t;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // threshold at its reset value of zero
    send_point(100, 500, 10, 1'b1);
    send_point(0, -100, 5, 1'b0);
    send_point(10, 100, 5, 1'b1);
    send_point(-32768, YHigh, 0, 1'b0);
    send_point(32767, YLow, 0, 1'b1);
    send_point(0, -100, 0, 1'b0);
    send_point(10, 0, 0, 1'b0);
    send_point(20, 100, 0, 1'b1);
    send_point(50, -300, 20, 1'b0);
    send_point(50, 300, 20, 1'b1);
    send_point(0, -100, 200, 1'b0);
    send_point(10, 100, 0, 1'b1);
    send_point(0, -50, 1, 1'b0);
    send_point(4, 50, 1, 1'b0);
    send_point(8, -50, 1, 1'b0);
    send_point(12, 50, 1, 1'b1);
    send_point(-32768, -10, 8388607, 1'b0);
    send_point(32767, 10, 8388588, 1'b1);
    send_point(0, -100, 0, 1'b1);
    send_point(10, 100, 0, 1'b1);

    goal = points_sent;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          t = int'($urandom_range(16777215)) - 8388608;
        end
        1: begin
          t = YHigh;
        end
        2: begin
          t = YLow;
        end
        3: begin
          t = int'($urandom_range(10000)) - 5000;
        end
        4: begin
          t = 0;
        end
        default: begin
          t = int'($urandom_range(16777215)) - 8388608;
        end
      endcase
      set_threshold(t);
      steady <= (ph == 3);
      goal += (ph == 1 || ph == 2) ? 40 : 140;
      while (points_sent < goal) random_scan();
    end
    steady <= 1'b0;

    drain();
    if (error_count == 0 && results_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
